// ===== rtl/core/dam_pkg.sv =====
// Shared constants and types for the differential axis mixer.
package dam_pkg;

  localparam int ANGLE_BITS_DEF = 32;
  localparam int GEAR_BITS_DEF  = 16;

  localparam int SPEED_W    = 32;
  localparam int RATIO_W    = 17;
  localparam int RATIO_FRAC = 16;
  localparam int NORM_W     = 32;
  localparam int RDIV_W     = NORM_W + RATIO_FRAC;

  localparam logic [RATIO_W-1:0] FLOOR_RATIO = 17'd3277;
  localparam logic [NORM_W-1:0]  NEAR_RAW    = 32'd3276;

  localparam int CFG_ADDR_W = 2;
  localparam logic [CFG_ADDR_W-1:0] REG_HEADING_GEAR   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_ELEVATION_GEAR = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_FULL_SPEED     = 2'd2;

  localparam logic [SPEED_W-1:0] FULL_SPEED_RST = 32'd1310720;
  localparam int HEADING_GEAR_RST   = 1536;
  localparam int ELEVATION_GEAR_RST = 210;

  typedef struct packed {
    logic vld;
    logic closed;
    logic near;
  } ctl_t;

endpackage

// ===== rtl/core/dam_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module dam_div #(
  parameter int DW = 48,
  parameter int VW = 32
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic [DW-1:0] quotient
);

  logic [DW-1:0] nq_r  [DW];
  logic [VW-1:0] rem_r [DW];
  logic [VW-1:0] dv_r  [DW];

  for (genvar k = 0; k < DW; k++) begin : g_stage
    logic [DW-1:0] nq_in;
    logic [VW-1:0] rem_in;
    logic [VW-1:0] dv_in;
    logic [VW:0]   trial;
    logic          ge;
    logic [VW-1:0] rem_nxt;
    logic [DW-1:0] nq_nxt;

    if (k == 0) begin : g_first
      assign nq_in  = dividend;
      assign rem_in = '0;
      assign dv_in  = divisor;
    end else begin : g_next
      assign nq_in  = nq_r[k-1];
      assign rem_in = rem_r[k-1];
      assign dv_in  = dv_r[k-1];
    end

    always_comb begin
      trial   = {rem_in, nq_in[DW-1]};
      ge      = trial >= {1'b0, dv_in};
      rem_nxt = ge ? VW'(trial - {1'b0, dv_in}) : trial[VW-1:0];
      nq_nxt  = {nq_in[DW-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nq_r[k]  <= nq_nxt;
        rem_r[k] <= rem_nxt;
        dv_r[k]  <= dv_in;
      end
    end
  end

  assign quotient = nq_r[DW-1];

endmodule

// ===== rtl/core/dam_front.sv =====
// Front pipeline: gear scaling, mixing, errors and normalisation.
module dam_front #(
  parameter int ANGLE_BITS = dam_pkg::ANGLE_BITS_DEF,
  parameter int GEAR_BITS  = dam_pkg::GEAR_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_vld,
  input  logic                         in_closed,
  input  logic signed [ANGLE_BITS-1:0] h_in,
  input  logic signed [ANGLE_BITS-1:0] e_in,
  input  logic signed [ANGLE_BITS-1:0] sa_in,
  input  logic signed [ANGLE_BITS-1:0] sb_in,
  input  logic [GEAR_BITS-1:0]         hg,
  input  logic [GEAR_BITS-1:0]         eg,
  output dam_pkg::ctl_t                ctl_o,
  output logic signed [ANGLE_BITS-1:0] ta_o,
  output logic signed [ANGLE_BITS-1:0] tb_o,
  output logic [dam_pkg::NORM_W-1:0]   err_a_o,
  output logic [dam_pkg::NORM_W-1:0]   err_b_o,
  output logic [dam_pkg::NORM_W-1:0]   mx_o,
  output logic [ANGLE_BITS:0]          sum_h_mag_o,
  output logic [ANGLE_BITS:0]          sum_e_mag_o,
  output logic                         sum_h_neg_o,
  output logic                         sum_e_neg_o
);

  localparam int A  = ANGLE_BITS;
  localparam int PW = ANGLE_BITS + GEAR_BITS;
  localparam int SW = PW - 8;
  localparam int XW = (A + 1 > dam_pkg::NORM_W) ? A + 1 : dam_pkg::NORM_W;
  localparam int SHN = XW - dam_pkg::NORM_W;
  localparam int SHW = (SHN > 0) ? $clog2(SHN + 1) : 1;
  localparam logic signed [A-1:0] AMAX = {1'b0, {(A-1){1'b1}}};
  localparam logic signed [A-1:0] AMIN = {1'b1, {(A-1){1'b0}}};
  localparam logic [SW-1:0] HALF = SW'(1) << (A - 1);

  dam_pkg::ctl_t ctl1_r, ctl2_r, ctl3_r, ctl4_r, ctl5_r;

  // stage 1: magnitude times gear
  logic [A-1:0]  mag_h, mag_e;
  logic [PW-1:0] prod_h_r, prod_e_r;
  logic          neg_h_r, neg_e_r;
  logic signed [A-1:0] sa1_r, sb1_r;

  always_comb begin
    mag_h = h_in[A-1] ? A'(~h_in + 1'b1) : h_in;
    mag_e = e_in[A-1] ? A'(~e_in + 1'b1) : e_in;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_h_r <= PW'(mag_h) * PW'(hg);
      prod_e_r <= PW'(mag_e) * PW'(eg);
      neg_h_r  <= h_in[A-1];
      neg_e_r  <= e_in[A-1];
      sa1_r    <= sa_in;
      sb1_r    <= sb_in;
    end
  end

  // stage 2: drop fraction, restore sign, saturate
  function automatic logic signed [A-1:0] gsat(input logic [SW-1:0] p, input logic neg);
    logic signed [A-1:0] res;
    if (neg) res = (p >= HALF) ? AMIN : -$signed(p[A-1:0]);
    else     res = (p >= HALF) ? AMAX : $signed(p[A-1:0]);
    return res;
  endfunction

  logic signed [A-1:0] hm2_r, em2_r, sa2_r, sb2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      hm2_r <= gsat(prod_h_r[PW-1:8], neg_h_r);
      em2_r <= gsat(prod_e_r[PW-1:8], neg_e_r);
      sa2_r <= sa1_r;
      sb2_r <= sb1_r;
    end
  end

  // stage 3: sum and difference
  function automatic logic signed [A-1:0] asat(input logic signed [A:0] s);
    logic signed [A-1:0] res;
    if (s[A] != s[A-1]) res = s[A] ? AMIN : AMAX;
    else                res = s[A-1:0];
    return res;
  endfunction

  logic signed [A:0]   mix_a, mix_b;
  logic signed [A-1:0] ta3_r, tb3_r, sa3_r, sb3_r;

  always_comb begin
    mix_a = {hm2_r[A-1], hm2_r} + {em2_r[A-1], em2_r};
    mix_b = {hm2_r[A-1], hm2_r} - {em2_r[A-1], em2_r};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ta3_r <= asat(mix_a);
      tb3_r <= asat(mix_b);
      sa3_r <= sa2_r;
      sb3_r <= sb2_r;
    end
  end

  // stage 4: errors and shaft sums
  function automatic logic [A:0] mag1(input logic signed [A:0] x);
    return x[A] ? (A+1)'(~x + 1'b1) : x;
  endfunction

  logic signed [A:0]   da, db, sh, se;
  logic [A:0]          ea4_r, eb4_r, shm4_r, sem4_r;
  logic                shn4_r, sen4_r;
  logic signed [A-1:0] ta4_r, tb4_r;

  always_comb begin
    da = {ta3_r[A-1], ta3_r} - {sa3_r[A-1], sa3_r};
    db = {tb3_r[A-1], tb3_r} - {sb3_r[A-1], sb3_r};
    sh = {sa3_r[A-1], sa3_r} + {sb3_r[A-1], sb3_r};
    se = {sa3_r[A-1], sa3_r} - {sb3_r[A-1], sb3_r};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ea4_r  <= mag1(da);
      eb4_r  <= mag1(db);
      shm4_r <= mag1(sh);
      sem4_r <= mag1(se);
      shn4_r <= sh[A];
      sen4_r <= se[A];
      ta4_r  <= ta3_r;
      tb4_r  <= tb3_r;
    end
  end

  // stage 5: larger error, near test, scale errors down to 32 bits
  logic [XW-1:0]  ea_x, eb_x, mx_x;
  logic [SHW-1:0] shift;
  logic           near;

  always_comb begin
    ea_x  = XW'(ea4_r);
    eb_x  = XW'(eb4_r);
    mx_x  = (ea_x > eb_x) ? ea_x : eb_x;
    near  = mx_x <= XW'(dam_pkg::NEAR_RAW);
    shift = '0;
    for (int s = SHN; s >= 0; s--) begin
      if (((mx_x >> s) >> dam_pkg::NORM_W) == '0) shift = SHW'(s);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      err_a_o     <= dam_pkg::NORM_W'(ea_x >> shift);
      err_b_o     <= dam_pkg::NORM_W'(eb_x >> shift);
      mx_o        <= dam_pkg::NORM_W'(mx_x >> shift);
      sum_h_mag_o <= shm4_r;
      sum_e_mag_o <= sem4_r;
      sum_h_neg_o <= shn4_r;
      sum_e_neg_o <= sen4_r;
      ta_o        <= ta4_r;
      tb_o        <= tb4_r;
    end
  end

  // control travels with the data
  dam_pkg::ctl_t ctl5_nxt;

  always_comb begin
    ctl5_nxt      = ctl4_r;
    ctl5_nxt.near = near;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
      ctl3_r <= '0;
      ctl4_r <= '0;
      ctl5_r <= '0;
    end else if (en) begin
      ctl1_r <= '{vld: in_vld, closed: in_closed, near: 1'b0};
      ctl2_r <= ctl1_r;
      ctl3_r <= ctl2_r;
      ctl4_r <= ctl3_r;
      ctl5_r <= ctl5_nxt;
    end
  end

  assign ctl_o = ctl5_r;

endmodule

// ===== rtl/core/differential_axis_mixer_top.sv =====
// Top level of the differential axis mixer.
//
// Input channel in_*: one item per handshake carrying the heading and
// elevation targets and both shaft angles in in_tdata, the closed-loop flag
// in in_tuser. Output channel out_*: one item per input item with the two
// motor targets, the per-motor speed limits and the measured angles in
// out_tdata, the limit-apply flag in out_tuser.
// Configuration: cfg_we/cfg_addr/cfg_wdata write the gear ratios and the
// full speed limit; write only while no item is in flight.
// Throughput: one item per cycle while the receiver accepts. Items pass
// through the front pipeline, the bit-per-stage dividers (DIV_W quotient
// bits, DIV_W = max(48, ANGLE_BITS + 8)) and a final register stage.
// The whole pipeline advances together; when the receiver holds off,
// every stage freezes and in_tready drops, so nothing is lost or repeated.
// Reset (rst_n low, synchronous) clears all valid bits and loads the
// default gears (6.0 and 0.82) and full speed limit (20 rad/s).
module differential_axis_mixer_top #(
  parameter int ANGLE_BITS = dam_pkg::ANGLE_BITS_DEF,
  parameter int GEAR_BITS  = dam_pkg::GEAR_BITS_DEF,
  localparam int IN_W  = ((4 * ANGLE_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((4 * ANGLE_BITS + 2 * dam_pkg::SPEED_W + 7) / 8) * 8,
  localparam int CFG_W = (GEAR_BITS > dam_pkg::SPEED_W) ? GEAR_BITS : dam_pkg::SPEED_W
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // heading_target, elevation_target, shaft_angle_a, shaft_angle_b
  input  logic [IN_W-1:0]                in_tdata,
  // closed_loop
  input  logic                           in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // motor_target_a, motor_target_b, speed_limit_a, speed_limit_b,
  // heading_measured, elevation_measured
  output logic [OUT_W-1:0]               out_tdata,
  // limits_apply
  output logic                           out_tuser,
  input  logic                           cfg_we,
  input  logic [dam_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]               cfg_wdata
);

  localparam int A     = ANGLE_BITS;
  localparam int SPW   = dam_pkg::SPEED_W;
  localparam int DIV_W = (A + 8 > dam_pkg::RDIV_W) ? A + 8 : dam_pkg::RDIV_W;
  localparam logic signed [A-1:0] AMAX = {1'b0, {(A-1){1'b1}}};
  localparam logic signed [A-1:0] AMIN = {1'b1, {(A-1){1'b0}}};
  localparam logic [DIV_W-1:0] QHALF = DIV_W'(1) << (A - 1);

  logic [GEAR_BITS-1:0] hgear_r, egear_r, hg, eg;
  logic [SPW-1:0]       full_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hgear_r <= GEAR_BITS'(dam_pkg::HEADING_GEAR_RST);
      egear_r <= GEAR_BITS'(dam_pkg::ELEVATION_GEAR_RST);
      full_r  <= dam_pkg::FULL_SPEED_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        dam_pkg::REG_HEADING_GEAR:   hgear_r <= cfg_wdata[GEAR_BITS-1:0];
        dam_pkg::REG_ELEVATION_GEAR: egear_r <= cfg_wdata[GEAR_BITS-1:0];
        dam_pkg::REG_FULL_SPEED:     full_r  <= cfg_wdata[SPW-1:0];
        default: ;
      endcase
    end
  end

  // zero gear counts as the smallest step
  assign hg = (hgear_r == '0) ? GEAR_BITS'(1) : hgear_r;
  assign eg = (egear_r == '0) ? GEAR_BITS'(1) : egear_r;

  logic en, fin_vld_r;
  assign en        = !fin_vld_r || out_tready;
  assign in_tready = en;

  dam_pkg::ctl_t               f_ctl;
  logic signed [A-1:0]         f_ta, f_tb;
  logic [dam_pkg::NORM_W-1:0]  f_ea, f_eb, f_mx;
  logic [A:0]                  f_shm, f_sem;
  logic                        f_shn, f_sen;

  dam_front #(.ANGLE_BITS(A), .GEAR_BITS(GEAR_BITS)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_vld      (in_tvalid),
    .in_closed   (in_tuser),
    .h_in        ($signed(in_tdata[A-1:0])),
    .e_in        ($signed(in_tdata[2*A-1:A])),
    .sa_in       ($signed(in_tdata[3*A-1:2*A])),
    .sb_in       ($signed(in_tdata[4*A-1:3*A])),
    .hg          (hg),
    .eg          (eg),
    .ctl_o       (f_ctl),
    .ta_o        (f_ta),
    .tb_o        (f_tb),
    .err_a_o     (f_ea),
    .err_b_o     (f_eb),
    .mx_o        (f_mx),
    .sum_h_mag_o (f_shm),
    .sum_e_mag_o (f_sem),
    .sum_h_neg_o (f_shn),
    .sum_e_neg_o (f_sen)
  );

  logic [DIV_W-1:0] q_ra, q_rb, q_hm, q_em;

  dam_div #(.DW(DIV_W), .VW(dam_pkg::NORM_W)) u_div_ra (
    .clk(clk), .en(en),
    .dividend(DIV_W'({f_ea, {dam_pkg::RATIO_FRAC{1'b0}}})),
    .divisor(f_mx), .quotient(q_ra)
  );

  dam_div #(.DW(DIV_W), .VW(dam_pkg::NORM_W)) u_div_rb (
    .clk(clk), .en(en),
    .dividend(DIV_W'({f_eb, {dam_pkg::RATIO_FRAC{1'b0}}})),
    .divisor(f_mx), .quotient(q_rb)
  );

  dam_div #(.DW(DIV_W), .VW(GEAR_BITS)) u_div_hm (
    .clk(clk), .en(en),
    .dividend(DIV_W'({f_shm, 7'b0})),
    .divisor(hg), .quotient(q_hm)
  );

  dam_div #(.DW(DIV_W), .VW(GEAR_BITS)) u_div_em (
    .clk(clk), .en(en),
    .dividend(DIV_W'({f_sem, 7'b0})),
    .divisor(eg), .quotient(q_em)
  );

  // side data alongside the dividers
  dam_pkg::ctl_t       dctl_r [DIV_W];
  logic signed [A-1:0] dta_r  [DIV_W];
  logic signed [A-1:0] dtb_r  [DIV_W];
  logic                dshn_r [DIV_W];
  logic                dsen_r [DIV_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DIV_W; k++) dctl_r[k] <= '0;
    end else if (en) begin
      dctl_r[0] <= f_ctl;
      for (int k = 1; k < DIV_W; k++) dctl_r[k] <= dctl_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dta_r[0]  <= f_ta;
      dtb_r[0]  <= f_tb;
      dshn_r[0] <= f_shn;
      dsen_r[0] <= f_sen;
      for (int k = 1; k < DIV_W; k++) begin
        dta_r[k]  <= dta_r[k-1];
        dtb_r[k]  <= dtb_r[k-1];
        dshn_r[k] <= dshn_r[k-1];
        dsen_r[k] <= dsen_r[k-1];
      end
    end
  end

  // final stage
  function automatic logic [SPW-1:0] limit(input logic [DIV_W-1:0] q,
                                           input logic [SPW-1:0] full);
    logic [dam_pkg::RATIO_W-1:0]       rt;
    logic [SPW+dam_pkg::RATIO_W-1:0]   p;
    rt = q[dam_pkg::RATIO_W-1:0];
    if (rt < dam_pkg::FLOOR_RATIO) rt = dam_pkg::FLOOR_RATIO;
    p = (SPW+dam_pkg::RATIO_W)'(full) * (SPW+dam_pkg::RATIO_W)'(rt);
    return p[SPW+dam_pkg::RATIO_FRAC-1:dam_pkg::RATIO_FRAC];
  endfunction

  function automatic logic signed [A-1:0] qsat(input logic [DIV_W-1:0] q, input logic neg);
    logic signed [A-1:0] res;
    if (neg) res = (q > QHALF) ? AMIN : -$signed(q[A-1:0]);
    else     res = (q >= QHALF) ? AMAX : $signed(q[A-1:0]);
    return res;
  endfunction

  dam_pkg::ctl_t       lc;
  logic [SPW-1:0]      la_nxt, lb_nxt;
  logic [SPW-1:0]      la_r, lb_r;
  logic signed [A-1:0] ta_r, tb_r, hm_r, em_r;
  logic                apply_r;

  always_comb begin
    lc = dctl_r[DIV_W-1];
    if (!lc.closed) begin
      la_nxt = '0;
      lb_nxt = '0;
    end else if (lc.near) begin
      la_nxt = full_r;
      lb_nxt = full_r;
    end else begin
      la_nxt = limit(q_ra, full_r);
      lb_nxt = limit(q_rb, full_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_vld_r <= 1'b0;
    end else if (en) begin
      fin_vld_r <= lc.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      la_r    <= la_nxt;
      lb_r    <= lb_nxt;
      ta_r    <= dta_r[DIV_W-1];
      tb_r    <= dtb_r[DIV_W-1];
      hm_r    <= qsat(q_hm, dshn_r[DIV_W-1]);
      em_r    <= qsat(q_em, dsen_r[DIV_W-1]);
      apply_r <= lc.closed;
    end
  end

  assign out_tvalid = fin_vld_r;
  assign out_tuser  = apply_r;
  assign out_tdata  = OUT_W'({em_r, hm_r, lb_r, la_r, tb_r, ta_r});

endmodule

// ===== rtl/core/dam_checker.sv =====
// Port-level checks for the differential axis mixer, bound to the top.
module dam_checker #(
  parameter int ANGLE_BITS = dam_pkg::ANGLE_BITS_DEF,
  parameter int OUT_W      = 192
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata,
  input logic             out_tuser
);

  localparam int LA_LO = 2 * ANGLE_BITS;
  localparam int SPW   = dam_pkg::SPEED_W;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output item changed while stalled");

  a_open_loop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[LA_LO+2*SPW-1:LA_LO] == '0)
    else $error("speed limits non-zero in open loop");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input held off while output drains");

endmodule

bind differential_axis_mixer_top dam_checker #(
  .ANGLE_BITS(ANGLE_BITS),
  .OUT_W(OUT_W)
) u_dam_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_tready(in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata(out_tdata),
  .out_tuser(out_tuser)
);
